// ----- rtl/core/isbs_pkg.sv -----
// Package for the serial bus byte sender: types, register indexes and reset values.
// No dependencies.
package isbs_pkg;

   localparam int CSR_W        = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int BYTE_W       = 8;
   localparam int DEF_BITS_PER_BYTE = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SETUP_DELAY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TIME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_IVAL    = 2'd3;

   localparam logic [CSR_W-1:0] RST_SETUP_DELAY = 16'd70;
   localparam logic [CSR_W-1:0] RST_BIT_TIME    = 16'd20;
   localparam logic [CSR_W-1:0] RST_POLL_COUNT  = 16'd100;
   localparam logic [CSR_W-1:0] RST_POLL_IVAL   = 16'd20;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SETUP = 4'b0010,
      PH_BIT   = 4'b0100,
      PH_ACK   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic clock_asserted;
      logic data_asserted;
      logic busy_res;
      logic done_res;
      logic acknowledged;
   } rsp_type;

endpackage

// ----- rtl/core/isbs_core.sv -----
// Sender state: configuration registers, bit/ack sequencing and line drives.
// Depends on isbs_pkg; one item is applied per accepted transfer.
module isbs_core import isbs_pkg::*; #(
   parameter int BITS_PER_BYTE = DEF_BITS_PER_BYTE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_take,
   input  logic                 in_mode,
   input  logic [BYTE_W-1:0]    in_byte,
   input  logic                 in_line,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 res_push,
   output rsp_type              res
);

   localparam int BIT_W = $clog2(BITS_PER_BYTE + 1);

   logic [CSR_W-1:0] setup_delay_ff, bit_time_ff, poll_count_ff, poll_ival_ff;

   phase_type         phase_ff, phase_in;
   logic [BIT_W-1:0]  bit_index_ff, bit_index_in, bit_next;
   logic [BYTE_W-1:0] shift_byte_ff, shift_byte_in;
   logic [CSR_W-1:0]  delay_left_ff, delay_left_in;
   logic [CSR_W-1:0]  polls_done_ff, polls_done_in;
   logic              clock_drive_ff, clock_drive_in;
   logic              data_drive_ff, data_drive_in;
   logic              done, ack;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_delay_ff <= RST_SETUP_DELAY;
         bit_time_ff    <= RST_BIT_TIME;
         poll_count_ff  <= RST_POLL_COUNT;
         poll_ival_ff   <= RST_POLL_IVAL;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SETUP_DELAY: setup_delay_ff <= csr_wdata;
            CSR_BIT_TIME:    bit_time_ff    <= csr_wdata;
            CSR_POLL_COUNT:  poll_count_ff  <= csr_wdata;
            CSR_POLL_IVAL:   poll_ival_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign bit_next = bit_index_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      shift_byte_in  = shift_byte_ff;
      delay_left_in  = delay_left_ff;
      polls_done_in  = polls_done_ff;
      clock_drive_in = clock_drive_ff;
      data_drive_in  = data_drive_ff;
      done           = 1'b0;
      ack            = 1'b0;
      if (in_take) begin
         if (in_mode == MODE_START) begin
            shift_byte_in  = in_byte;
            bit_index_in   = '0;
            polls_done_in  = '0;
            delay_left_in  = setup_delay_ff;
            clock_drive_in = 1'b1;
            data_drive_in  = 1'b0;
            phase_in       = PH_SETUP;
         end else if (phase_ff != PH_IDLE) begin
            if (delay_left_ff != '0) begin
               delay_left_in = delay_left_ff - 1'b1;
            end else begin
               case (phase_ff)
                  PH_SETUP: begin
                     if (!shift_byte_ff[0]) data_drive_in = 1'b1;
                     clock_drive_in = 1'b0;
                     delay_left_in  = bit_time_ff;
                     phase_in       = PH_BIT;
                  end
                  PH_BIT: begin
                     clock_drive_in = 1'b1;
                     data_drive_in  = 1'b0;
                     shift_byte_in  = shift_byte_ff >> 1;
                     if (bit_next >= BIT_W'(BITS_PER_BYTE)) begin
                        bit_index_in  = '0;
                        polls_done_in = '0;
                        delay_left_in = '0;
                        phase_in      = PH_ACK;
                     end else begin
                        bit_index_in  = bit_next;
                        delay_left_in = setup_delay_ff;
                        phase_in      = PH_SETUP;
                     end
                  end
                  PH_ACK: begin
                     if (polls_done_ff >= poll_count_ff) begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end else if (in_line) begin
                        done     = 1'b1;
                        ack      = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        polls_done_in = polls_done_ff + 1'b1;
                        delay_left_in = poll_ival_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_index_ff   <= '0;
         shift_byte_ff  <= '0;
         delay_left_ff  <= '0;
         polls_done_ff  <= '0;
         clock_drive_ff <= 1'b1;
         data_drive_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         bit_index_ff   <= bit_index_in;
         shift_byte_ff  <= shift_byte_in;
         delay_left_ff  <= delay_left_in;
         polls_done_ff  <= polls_done_in;
         clock_drive_ff <= clock_drive_in;
         data_drive_ff  <= data_drive_in;
      end
   end

   assign res_push           = in_take;
   assign res.clock_asserted = clock_drive_in;
   assign res.data_asserted  = data_drive_in;
   assign res.busy_res       = (phase_in != PH_IDLE);
   assign res.done_res       = done;
   assign res.acknowledged   = ack;

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      in_take && in_mode == MODE_START
      |=> phase_ff == PH_SETUP && clock_drive_ff && !data_drive_ff)
      else $error("start did not load setup phase");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      in_take && in_mode == MODE_TICK && phase_ff == PH_IDLE
      |=> phase_ff == PH_IDLE && $stable(clock_drive_ff) && $stable(data_drive_ff))
      else $error("tick while idle changed state");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      in_take && done |=> phase_ff == PH_IDLE)
      else $error("done without return to idle");

   a_clock_released_in_bit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BIT |-> !clock_drive_ff)
      else $error("clock asserted during bit time");

endmodule

// ----- rtl/core/isbs_outq.sv -----
// Two-entry result queue between the sender state and the rsp channel.
// Depends on isbs_pkg.
module isbs_outq import isbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rsp_type    entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full result queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("transfer out did not drain queue");

endmodule

// ----- rtl/core/iec_serial_byte_sender.sv -----
// Top level of the serial bus byte sender: sender state plus result queue.
// Depends on isbs_pkg, isbs_core, isbs_outq.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_mode, req_byte_value, req_data_line_in
//   rsp      out        rsp_valid/rsp_stall  rsp_clock_asserted .. rsp_acknowledged
//   csr      in         csr_write            csr_index, csr_wdata
//
// One req per cycle unless req_stall; its result is in the rsp queue in the next cycle.
// The two-entry result queue sets the rate: req_stall rises only when it is full.
// Reset is synchronous: idle, clock asserted, data released, registers at defaults.
// A stalled rsp keeps its payload; req is taken while one result still waits.
module iec_serial_byte_sender import isbs_pkg::*; #(
   parameter int BITS_PER_BYTE = DEF_BITS_PER_BYTE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [BYTE_W-1:0]    req_byte_value,
   input  logic                 req_data_line_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_clock_asserted,
   output logic                 rsp_data_asserted,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic                 rsp_acknowledged,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic    take, push, full;
   rsp_type res, rsp_data;

   assign req_stall = full;
   assign take      = req_valid && !full;

   isbs_core #(
      .BITS_PER_BYTE(BITS_PER_BYTE)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_take  (take),
      .in_mode  (req_mode),
      .in_byte  (req_byte_value),
      .in_line  (req_data_line_in),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .res_push (push),
      .res      (res)
   );

   isbs_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(res),
      .full     (full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   assign rsp_clock_asserted = rsp_data.clock_asserted;
   assign rsp_data_asserted  = rsp_data.data_asserted;
   assign rsp_busy_res       = rsp_data.busy_res;
   assign rsp_done_res       = rsp_data.done_res;
   assign rsp_acknowledged   = rsp_data.acknowledged;

endmodule
